// ===== src/cma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and the division step for the count multiset algebra block
// depends on nothing; every other file takes names from here by scope

package cma_pkg;

	localparam int NUM_COLORS = 8;
	localparam int COUNT_BITS = 8;
	localparam int LANES_W    = NUM_COLORS * COUNT_BITS;
	localparam int KIND_W     = 3;
	localparam int DATA_W     = 64;
	localparam int FIT_W      = 8;
	// one quotient bit per stage
	localparam int DIV_STAGES = COUNT_BITS;

	localparam logic [KIND_W-1:0] KIND_UNION = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INTER = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DIFF  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INCL  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ONE   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FIT   = 3'd5;

	localparam logic [FIT_W-1:0] FIT_MAX = '1;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic incl_ok;
		logic one_ok;
		logic sat;
		logic nz;
	} lane_flags_t;

	typedef struct packed {
		count_t      count;
		count_t      quo;
		lane_flags_t flags;
	} lane_res_t;

	typedef struct packed {
		logic [DATA_W-1:0] result_counts;
		logic              truth_flag;
		logic [FIT_W-1:0]  times_fit;
		logic              saturated;
	} out_beat_t;

	typedef struct packed {
		count_t rem;
		logic   qbit;
	} div_step_t;

	// one restoring division step: bring down a dividend bit, subtract if it fits
	function automatic div_step_t div_step(input count_t rem, input logic xb, input count_t y);
		logic [COUNT_BITS:0] t;
		logic [COUNT_BITS:0] d;
		div_step_t r;
		t = {rem, xb};
		d = t - {1'b0, y};
		if (t >= {1'b0, y}) begin
			r.rem  = d[COUNT_BITS-1:0];
			r.qbit = 1'b1;
		end else begin
			r.rem  = t[COUNT_BITS-1:0];
			r.qbit = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/cma_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// operand channel: valid/ready handshake with kind and two packed multisets
// depends on cma_pkg

interface cma_in_if;
	logic                           valid;
	logic                           ready;
	logic [cma_pkg::KIND_W-1:0]     kind;
	logic [cma_pkg::DATA_W-1:0]     first_counts;
	logic [cma_pkg::DATA_W-1:0]     second_counts;

	modport source (output valid, output kind, output first_counts, output second_counts,
		input ready);
	modport sink (input valid, input kind, input first_counts, input second_counts,
		output ready);
endinterface

`default_nettype wire

// ===== src/cma_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result channel: valid/ready handshake with packed counts, test flag and fit count
// depends on cma_pkg

interface cma_out_if;
	logic                        valid;
	logic                        ready;
	logic [cma_pkg::DATA_W-1:0]  result_counts;
	logic                        truth_flag;
	logic [cma_pkg::FIT_W-1:0]   times_fit;
	logic                        saturated;

	modport source (output valid, output result_counts, output truth_flag, output times_fit,
		output saturated, input ready);
	modport sink (input valid, input result_counts, input truth_flag, input times_fit,
		input saturated, output ready);
endinterface

`default_nettype wire

// ===== src/count_multiset_algebra.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Dense multiset algebra on two packed count vectors: union, intersection, difference,
// inclusion test, one-to-one test and fit count. Takes one operand beat per cycle unless
// stalled and gives one result beat per operand beat, in order. When an operand beat is
// taken, the first stage of the per-lane restoring divider captures it, COUNT_BITS - 1
// more stages follow, one quotient bit each, and the merge feeds the output register.
// The whole pipeline moves together, and only stalls while the output register holds a
// beat the consumer has not taken.

module count_multiset_algebra (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cma_in_if.sink     operands,
	cma_out_if.source  results
);

	localparam int CB = cma_pkg::COUNT_BITS;
	localparam int NS = cma_pkg::DIV_STAGES;
	localparam int NC = cma_pkg::NUM_COLORS;

	// pipeline advances whenever the output register is free or being drained
	logic adv;

	// control pipeline alongside the lanes
	logic                       vld_s  [NS];
	logic [cma_pkg::KIND_W-1:0] kind_s [NS];

	cma_pkg::lane_res_t lane_res [NC];
	cma_pkg::out_beat_t merged;

	logic               out_vld_q;
	cma_pkg::out_beat_t out_q;

	assign adv            = ~out_vld_q | results.ready;
	assign operands.ready = adv;

	// one copy of the lane core per color, each on its own slice of the operands
	for (genvar i = 0; i < NC; i++) begin : gen_lane
		cma_lane u_lane (
			.clk  (clk),
			.adv  (adv),
			.kind (operands.kind),
			.x    (operands.first_counts[i*CB +: CB]),
			.y    (operands.second_counts[i*CB +: CB]),
			.res  (lane_res[i])
		);
	end

	// valid bits follow the lanes, one per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS; j++)
				vld_s[j] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= operands.valid;
			for (int j = 1; j < NS; j++)
				vld_s[j] <= vld_s[j-1];
		end
	end

	// kind rides along for the merge stage
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s[0] <= operands.kind;
			for (int j = 1; j < NS; j++)
				kind_s[j] <= kind_s[j-1];
		end
	end

	cma_merge u_merge (
		.kind  (kind_s[NS-1]),
		.lanes (lane_res),
		.beat  (merged)
	);

	// output register parts the pipeline from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= merged;
	end

	assign results.valid         = out_vld_q;
	assign results.result_counts = out_q.result_counts;
	assign results.truth_flag    = out_q.truth_flag;
	assign results.times_fit     = out_q.times_fit;
	assign results.saturated     = out_q.saturated;

	// a beat leaving the last lane stage lands in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-1] && adv |=> results.valid)
		else $error("last stage beat lost on its way to the output register");

	// a test answer comes with no counts and no fit
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.truth_flag |->
			results.result_counts == '0 && results.times_fit == '0 && !results.saturated)
		else $error("test result mixed with other fields");

	// a fit count comes with no counts
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.times_fit != '0 |-> results.result_counts == '0)
		else $error("fit count mixed with packed counts");

	// union overflow leaves at least one lane at its maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.saturated && results.times_fit == '0 |->
			results.result_counts != '0)
		else $error("union saturation flagged with empty counts");

endmodule

`default_nettype wire

// ===== src/cma_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one color lane: lane-wise count operation, lane flags and a pipelined restoring divider
// depends on cma_pkg

module cma_lane (
	input  wire logic                        clk,
	input  wire logic                        adv,
	input  wire logic [cma_pkg::KIND_W-1:0]  kind,
	input  wire cma_pkg::count_t             x,
	input  wire cma_pkg::count_t             y,
	output cma_pkg::lane_res_t               res
);

	localparam int CB = cma_pkg::COUNT_BITS;
	localparam int NS = cma_pkg::DIV_STAGES;

	cma_pkg::count_t      x_s    [NS];
	cma_pkg::count_t      y_s    [NS];
	cma_pkg::count_t      rem_s  [NS];
	cma_pkg::count_t      quo_s  [NS];
	cma_pkg::count_t      cnt_s  [NS];
	cma_pkg::lane_flags_t flags_s[NS];

	logic [CB:0]          sum;
	cma_pkg::count_t      cnt_d;
	cma_pkg::lane_flags_t flags_d;
	cma_pkg::div_step_t   step0;

	assign sum   = {1'b0, x} + {1'b0, y};
	assign step0 = cma_pkg::div_step('0, x[CB-1], y);

	always_comb begin
		unique case (kind)
			cma_pkg::KIND_UNION: cnt_d = sum[CB] ? '1 : sum[CB-1:0];
			cma_pkg::KIND_INTER: cnt_d = (x < y) ? x : y;
			cma_pkg::KIND_DIFF:  cnt_d = (x > y) ? (x - y) : '0;
			default:             cnt_d = '0;
		endcase
		flags_d.incl_ok = (x >= y);
		flags_d.one_ok  = (x == '0) || (x == CB'(1));
		flags_d.sat     = (kind == cma_pkg::KIND_UNION) && sum[CB];
		flags_d.nz      = (y != '0);
	end

	// first stage: lane op, flags and the top quotient bit
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]          <= x;
			y_s[0]          <= y;
			rem_s[0]        <= step0.rem;
			quo_s[0]        <= cma_pkg::count_t'(step0.qbit) << (CB-1);
			cnt_s[0]        <= cnt_d;
			flags_s[0]      <= flags_d;
		end
	end

	// later stages: one quotient bit each
	for (genvar j = 1; j < NS; j++) begin : gen_div
		cma_pkg::div_step_t st;
		assign st = cma_pkg::div_step(rem_s[j-1], x_s[j-1][CB-1-j], y_s[j-1]);

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[j]          <= x_s[j-1];
				y_s[j]          <= y_s[j-1];
				rem_s[j]        <= st.rem;
				quo_s[j]        <= quo_s[j-1] | (cma_pkg::count_t'(st.qbit) << (CB-1-j));
				cnt_s[j]        <= cnt_s[j-1];
				flags_s[j]      <= flags_s[j-1];
			end
		end
	end

	assign res.count = cnt_s[NS-1];
	assign res.quo   = quo_s[NS-1];
	assign res.flags = flags_s[NS-1];

endmodule

`default_nettype wire

// ===== src/cma_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// merge of the lane results: packing, flag reduction and minimum quotient, chosen by kind
// depends on cma_pkg

module cma_merge (
	input  wire logic [cma_pkg::KIND_W-1:0]  kind,
	input  wire cma_pkg::lane_res_t          lanes [cma_pkg::NUM_COLORS],
	output cma_pkg::out_beat_t               beat
);

	localparam int CB = cma_pkg::COUNT_BITS;

	always_comb begin
		logic [cma_pkg::DATA_W-1:0] packed_cnt;
		logic [cma_pkg::FIT_W-1:0]  best;
		logic                       any_nz;
		logic                       incl;
		logic                       one;
		logic                       usat;

		packed_cnt = '0;
		best       = cma_pkg::FIT_MAX;
		any_nz     = 1'b0;
		incl       = 1'b1;
		one        = 1'b1;
		usat       = 1'b0;
		for (int i = 0; i < cma_pkg::NUM_COLORS; i++) begin
			packed_cnt[i*CB +: CB] = lanes[i].count;
			incl = incl & lanes[i].flags.incl_ok;
			one  = one & lanes[i].flags.one_ok;
			usat = usat | lanes[i].flags.sat;
			if (lanes[i].flags.nz) begin
				any_nz = 1'b1;
				if (cma_pkg::FIT_W'(lanes[i].quo) < best)
					best = cma_pkg::FIT_W'(lanes[i].quo);
			end
		end

		beat.result_counts = packed_cnt;
		beat.truth_flag    = 1'b0;
		beat.times_fit     = '0;
		beat.saturated     = 1'b0;
		unique case (kind)
			cma_pkg::KIND_UNION: beat.saturated = usat;
			cma_pkg::KIND_INCL:  beat.truth_flag = incl;
			cma_pkg::KIND_ONE:   beat.truth_flag = one;
			cma_pkg::KIND_FIT: begin
				beat.times_fit = any_nz ? best : cma_pkg::FIT_MAX;
				beat.saturated = ~any_nz;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// self-checking bench for count_multiset_algebra: directed and random operand beats
// depends on cma_pkg, cma_in_if, cma_out_if and the block itself

module tb;

	localparam int KW = cma_pkg::KIND_W;
	localparam int DW = cma_pkg::DATA_W;
	localparam int FW = cma_pkg::FIT_W;
	localparam int CB = cma_pkg::COUNT_BITS;
	localparam int NC = cma_pkg::NUM_COLORS;

	// kinds that the block does not define; it must answer them with an all-zero beat
	localparam logic [KW-1:0] KIND_SPARE6 = 3'd6;
	localparam logic [KW-1:0] KIND_SPARE7 = 3'd7;

	// pipeline depth, lane stages plus the output register, and the settle time at the end
	localparam int PIPE_DEPTH   = CB + 1;
	localparam int DRAIN_CYCLES = 3 * PIPE_DEPTH;
	// cycles without any beat on either channel before the run is declared hung
	localparam int HANG_LIMIT   = 2000;
	localparam int MAX_REPORTS  = 40;

	localparam cma_pkg::count_t LANE_TOP = '1;

	typedef struct {
		logic [KW-1:0]      kind;
		cma_pkg::out_beat_t want;
	} awaited_t;

	logic clk;
	logic arst_n;

	cma_in_if  operands ();
	cma_out_if results ();

	count_multiset_algebra dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operands(operands),
		.results (results)
	);

	// results still owed by the block, oldest first
	awaited_t awaited_results[$];

	int mismatches    = 0;
	int beats_checked = 0;
	int kinds_sent[8];
	int idle_cycles   = 0;

	// when set, the matching side never idles, so beats run back to back
	bit steady_source = 1'b0;
	bit steady_sink   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// prediction: what the block must return for one operand beat
	// ---------------------------------------------------------------------

	function automatic cma_pkg::out_beat_t algebra_result(logic [KW-1:0] kind,
		logic [DW-1:0] a, logic [DW-1:0] b);
		cma_pkg::out_beat_t r;
		int unsigned x;
		int unsigned y;
		int unsigned lane;
		int unsigned best;
		bit          covers;
		bit          all_single;
		bit          any_second;
		bit          overflow;
		int          i;
		r          = '0;
		covers     = 1'b1;
		all_single = 1'b1;
		any_second = 1'b0;
		overflow   = 1'b0;
		best       = 32'(cma_pkg::FIT_MAX);
		for (i = 0; i < NC; i++) begin
			x    = 32'(a[i*CB +: CB]);
			y    = 32'(b[i*CB +: CB]);
			lane = 0;
			case (kind)
				cma_pkg::KIND_UNION: begin
					lane = x + y;
					if (lane > LANE_TOP) begin
						lane     = 32'(LANE_TOP);
						overflow = 1'b1;
					end
				end
				cma_pkg::KIND_INTER: lane = (x < y) ? x : y;
				cma_pkg::KIND_DIFF:  lane = (x > y) ? x - y : 0;
				default:             lane = 0;
			endcase
			r.result_counts[i*CB +: CB] = cma_pkg::count_t'(lane);
			if (x < y)
				covers = 1'b0;
			if (x > 1)
				all_single = 1'b0;
			// lanes where the second multiset is absent place no bound on the fit
			if (y != 0) begin
				any_second = 1'b1;
				if (x / y < best)
					best = x / y;
			end
		end
		case (kind)
			cma_pkg::KIND_UNION: r.saturated  = overflow;
			cma_pkg::KIND_INCL:  r.truth_flag = covers;
			cma_pkg::KIND_ONE:   r.truth_flag = all_single;
			cma_pkg::KIND_FIT: begin
				// an empty second fits without bound: pin to the top and flag it
				if (any_second) begin
					r.times_fit = best[FW-1:0];
				end else begin
					r.times_fit = cma_pkg::FIT_MAX;
					r.saturated = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// source side: one operand beat per call
	// ---------------------------------------------------------------------

	function automatic int draw_wait(bit steady);
		return steady ? 0 : int'($urandom_range(0, 10));
	endfunction

	// valid stays high from one beat to the next when no gap is drawn, so it is
	// never lowered and raised within the same step
	task automatic send_operands(logic [KW-1:0] kind, logic [DW-1:0] a,
		logic [DW-1:0] b);
		int gap;
		gap = draw_wait(steady_source);
		if (gap > 0) begin
			operands.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operands.valid         <= 1'b1;
		operands.kind          <= kind;
		operands.first_counts  <= a;
		operands.second_counts <= b;
		do @(posedge clk); while (!operands.ready);
		// beat taken at this edge
		awaited_results.push_back('{kind: kind, want: algebra_result(kind, a, b)});
		kinds_sent[kind]++;
	endtask

	// ---------------------------------------------------------------------
	// sink side: stalls at random, compares every result beat in order
	// ---------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [DW-1:0] got,
		logic [DW-1:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("tb: result beat %0d: %s got %h want %h", beats_checked, what, got, want);
	endtask

	initial begin
		awaited_t  w;
		int        stall;
		results.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(steady_sink);
			if (stall > 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
			// values seen here are the ones the edge took
			if (awaited_results.size() == 0) begin
				report_mismatch("beat with nothing owed", results.result_counts, '0);
			end else begin
				w = awaited_results.pop_front();
				if (results.result_counts !== w.want.result_counts)
					report_mismatch($sformatf("kind %0d result_counts", w.kind),
						results.result_counts, w.want.result_counts);
				if (results.truth_flag !== w.want.truth_flag)
					report_mismatch($sformatf("kind %0d truth_flag", w.kind),
						DW'(results.truth_flag), DW'(w.want.truth_flag));
				if (results.times_fit !== w.want.times_fit)
					report_mismatch($sformatf("kind %0d times_fit", w.kind),
						DW'(results.times_fit), DW'(w.want.times_fit));
				if (results.saturated !== w.want.saturated)
					report_mismatch($sformatf("kind %0d saturated", w.kind),
						DW'(results.saturated), DW'(w.want.saturated));
			end
			beats_checked++;
		end
	end

	// hang guard: any beat on either channel clears the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((operands.valid && operands.ready) || (results.valid && results.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("tb: no beat moved for %0d cycles, %0d results still owed",
					idle_cycles, awaited_results.size());
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// operand shaping for the random part
	// ---------------------------------------------------------------------

	function automatic cma_pkg::count_t splat_free_lane();
		case ($urandom_range(0, 3))
			0: return cma_pkg::count_t'($urandom_range(0, 3));
			1: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return LANE_TOP;
					2: return cma_pkg::count_t'(1 << (CB - 1));
					default: return cma_pkg::count_t'((1 << (CB - 1)) - 1);
				endcase
			end
			default: return cma_pkg::count_t'($urandom);
		endcase
	endfunction

	// mostly lane-wise picks with plenty of absent colours, now and then raw bits
	function automatic logic [DW-1:0] pick_counts();
		logic [DW-1:0] v;
		int            i;
		v = '0;
		if ($urandom_range(0, 4) == 0)
			return {$urandom, $urandom};
		for (i = 0; i < NC; i++)
			v[i*CB +: CB] = ($urandom_range(0, 3) == 0) ? '0 : splat_free_lane();
		return v;
	endfunction

	// random beat whose operands are bent towards the interesting answers of its kind
	task automatic send_shaped();
		logic [KW-1:0] kind;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		int unsigned   x;
		int unsigned   y;
		int unsigned   k;
		int            i;
		int            hit;
		kind = ($urandom_range(0, 19) == 0)
			? (($urandom_range(0, 1) == 0) ? KIND_SPARE6 : KIND_SPARE7)
			: KW'($urandom_range(0, 5));
		a = pick_counts();
		b = pick_counts();
		case (kind)
			cma_pkg::KIND_INCL: begin
				// second mostly at or below first, sometimes with one lane pushed just above
				if ($urandom_range(0, 9) < 7) begin
					for (i = 0; i < NC; i++) begin
						x = 32'(a[i*CB +: CB]);
						b[i*CB +: CB] = cma_pkg::count_t'($urandom_range(0, x));
					end
					if ($urandom_range(0, 2) == 0) begin
						hit = int'($urandom_range(0, NC - 1));
						x   = 32'(a[hit*CB +: CB]);
						if (x < LANE_TOP)
							b[hit*CB +: CB] = cma_pkg::count_t'(x + 1);
					end
				end
			end
			cma_pkg::KIND_ONE: begin
				// first made of single copies, one lane sometimes spoilt
				if ($urandom_range(0, 9) < 6) begin
					for (i = 0; i < NC; i++)
						a[i*CB +: CB] = cma_pkg::count_t'($urandom_range(0, 1));
					if ($urandom_range(0, 2) == 0) begin
						hit = int'($urandom_range(0, NC - 1));
						a[hit*CB +: CB] = splat_free_lane();
					end
				end
			end
			cma_pkg::KIND_FIT: begin
				// small second, first a multiple of it plus a remainder
				if ($urandom_range(0, 11) == 0) begin
					b = '0;
				end else if ($urandom_range(0, 4) != 0) begin
					for (i = 0; i < NC; i++) begin
						case ($urandom_range(0, 2))
							0: y = 0;
							1: y = $urandom_range(1, 15);
							default: y = 32'(splat_free_lane());
						endcase
						k = $urandom_range(0, 20);
						x = y * k + $urandom_range(0, (y > 0) ? y - 1 : 3);
						if (x > LANE_TOP)
							x = 32'(LANE_TOP);
						b[i*CB +: CB] = cma_pkg::count_t'(y);
						a[i*CB +: CB] = cma_pkg::count_t'(x);
					end
				end
			end
			default: ;
		endcase
		send_operands(kind, a, b);
	endtask

	// ---------------------------------------------------------------------
	// directed tests
	// ---------------------------------------------------------------------

	task automatic test_union();
		send_operands(cma_pkg::KIND_UNION, '0, '0);
		send_operands(cma_pkg::KIND_UNION, 64'h0102_0304_0506_0708, 64'h1010_1010_1010_1010);
		// lowest lane overflows by one
		send_operands(cma_pkg::KIND_UNION, 64'h0000_0000_0000_00FF, 64'h0000_0000_0000_0001);
		send_operands(cma_pkg::KIND_UNION, '1, '1);
		// every lane lands exactly on the top without overflow
		send_operands(cma_pkg::KIND_UNION, 64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F);
	endtask

	task automatic test_intersection_difference();
		send_operands(cma_pkg::KIND_INTER, 64'hFF00_FF00_FF00_FF00, 64'h0F0F_0F0F_0F0F_0F0F);
		send_operands(cma_pkg::KIND_INTER, '1, '0);
		send_operands(cma_pkg::KIND_DIFF, 64'h1020_1020_1020_1020, 64'h2010_2010_2010_2010);
		send_operands(cma_pkg::KIND_DIFF, 64'h5A5A_A5A5_0102_FEFF, 64'h5A5A_A5A5_0102_FEFF);
		send_operands(cma_pkg::KIND_DIFF, '1, '0);
	endtask

	task automatic test_includes();
		send_operands(cma_pkg::KIND_INCL, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0);
		send_operands(cma_pkg::KIND_INCL, '1, '0);
		// one colour of the second missing from the first, in the top lane
		send_operands(cma_pkg::KIND_INCL, '0, 64'h0100_0000_0000_0000);
		send_operands(cma_pkg::KIND_INCL, '0, '0);
	endtask

	task automatic test_one_to_one();
		// empty first counts as one-to-one
		send_operands(cma_pkg::KIND_ONE, '0, '1);
		send_operands(cma_pkg::KIND_ONE, 64'h0101_0101_0101_0101, '0);
		send_operands(cma_pkg::KIND_ONE, 64'h0101_0001_0100_0102, 64'hFFFF_FFFF_0000_0000);
		send_operands(cma_pkg::KIND_ONE, '1, '0);
	endtask

	task automatic test_fit_count();
		// empty second: unbounded, pinned and flagged
		send_operands(cma_pkg::KIND_FIT, '1, '0);
		// every lane fits 255 times, but that is a real bound, not a saturation
		send_operands(cma_pkg::KIND_FIT, '1, 64'h0101_0101_0101_0101);
		send_operands(cma_pkg::KIND_FIT, '0, 64'h0102_0304_0506_0708);
		send_operands(cma_pkg::KIND_FIT, 64'hFFFF_FFFF_FFFF_FF0C, 64'h0000_0000_0000_0003);
		send_operands(cma_pkg::KIND_FIT, 64'h0000_0000_0000_140A, 64'h0000_0000_0000_0405);
	endtask

	task automatic test_spare_kinds();
		send_operands(KIND_SPARE6, {$urandom, $urandom}, {$urandom, $urandom});
		send_operands(KIND_SPARE7, '1, '1);
	endtask

	// ---------------------------------------------------------------------
	// random streams: four stretches covering every mix of steady and idling sides
	// ---------------------------------------------------------------------

	task automatic test_random_streams();
		int phase;
		int n;
		for (phase = 0; phase < 4; phase++) begin
			steady_source = phase[0];
			steady_sink   = phase[1];
			for (n = 0; n < 312; n++)
				send_shaped();
		end
		steady_source = 1'b0;
		steady_sink   = 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------

	initial begin
		arst_n                 = 1'b0;
		operands.valid         = 1'b0;
		operands.kind          = '0;
		operands.first_counts  = '0;
		operands.second_counts = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_union();
		test_intersection_difference();
		test_includes();
		test_one_to_one();
		test_fit_count();
		test_spare_kinds();
		test_random_streams();

		// last beat taken: drop valid and let the pipeline empty
		operands.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: sent union %0d, intersection %0d, difference %0d, includes %0d,",
			kinds_sent[0], kinds_sent[1], kinds_sent[2], kinds_sent[3]);
		$display("tb: one-to-one %0d, fit %0d, spare %0d; %0d results compared, %0d faults",
			kinds_sent[4], kinds_sent[5], kinds_sent[6] + kinds_sent[7], beats_checked,
			mismatches);
		if (mismatches == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== count_multiset_algebra.f =====
src/cma_pkg.sv
src/cma_in_if.sv
src/cma_out_if.sv
src/cma_lane.sv
src/cma_merge.sv
src/count_multiset_algebra.sv
tb/tb.sv
